/* src/bcdr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcdr_pkg: shared definitions for the packed-BCD repacker
// Width codes, configuration register indexes and the nibble-weighting
// helpers used by the repacker.
// ----------------------------------------------------------------------------
package bcdr_pkg;

    localparam int WORD_W  = 32;
    localparam int VALUE_W = 28;
    localparam int PEND_W  = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 2;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_INPUT_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUTPUT_WIDTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SKIP_ZEROS   = 2'd2;

    // Width codes; the unused code behaves as four bytes.
    localparam logic [1:0] WCODE_ONE = 2'd0;
    localparam logic [1:0] WCODE_TWO = 2'd1;

    typedef logic [WORD_W-1:0]  t_group;
    typedef logic [VALUE_W-1:0] t_value;

    localparam t_value BCD_WEIGHT [8] = '{
        28'd1, 28'd10, 28'd100, 28'd1000,
        28'd10000, 28'd100000, 28'd1000000, 28'd10000000
    };

    // Number of bytes for a width code.
    function automatic logic [2:0] size_of_code(input logic [1:0] code);
        logic [2:0] sz;
        case (code)
            WCODE_ONE: sz = 3'd1;
            WCODE_TWO: sz = 3'd2;
            default:   sz = 3'd4;
        endcase
        return sz;
    endfunction

    // Keeps the low nbytes bytes of x.
    function automatic t_group low_bytes(input t_group x, input logic [2:0] nbytes);
        t_group r;
        case (nbytes)
            3'd1:    r = {24'h000000, x[7:0]};
            3'd2:    r = {16'h0000, x[15:0]};
            3'd3:    r = {8'h00, x[23:0]};
            default: r = x;
        endcase
        return r;
    endfunction

    // Weights every nibble with its decimal power. Zero upper bytes add
    // nothing, so one form serves all group sizes.
    function automatic t_value bcd_to_bin(input t_group x);
        t_value v;
        v = '0;
        for (int k = 0; k < 8; k++) begin
            v = v + VALUE_W'(t_value'(x[k*4 +: 4]) * BCD_WEIGHT[k]);
        end
        return v;
    endfunction

endpackage
`default_nettype wire

/* src/bcd_repack_to_binary.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bcd_repack_to_binary: packed-BCD words regrouped and converted to binary
// Input words of 1, 2 or 4 bytes are appended to a byte stream, cut into
// groups of 1, 2 or 4 bytes, and each group is weighted nibble by nibble.
//
// Usage: an input word is taken when i_in_valid is high and o_in_stall is
// low. Its bytes are sorted into groups in the cycle it is taken; the closed
// groups sit in a four-entry result buffer. A drain pointer moves one group
// per cycle, while the output is not stalled, into the output register,
// where the nibble weighting is done. A word yields 0 to 4 groups; words
// are taken at one a cycle when every word closes at most one group and
// the output is not stalled. The next word is taken in the cycle the last
// buffered group moves to the output register.
// While i_out_stall is high and a result word is valid, the output word
// holds and the buffer does not drain; o_in_stall is high while the buffer
// holds groups and its last group is not moving to the output register.
// Reset (i_rst_n low, synchronous) empties the buffer and the output
// register, clears the open group and zeroes the configuration registers;
// the buffered groups and the output value and flag are not reset.
// Configuration is written through i_cfg_we / i_cfg_idx / i_cfg_data.
// ----------------------------------------------------------------------------
module bcd_repack_to_binary
    import bcdr_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    // configuration
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    // input words
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic [WORD_W-1:0]     i_bcd_word,
    input  wire logic                  i_final_word,
    // result words
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [VALUE_W-1:0]         o_binary_value,
    output logic                       o_final_result
);

    // Configuration registers.
    logic [1:0] r_in_width;
    logic [1:0] r_out_width;
    logic       r_skip_zeros;

    // Stream state.
    logic [PEND_W-1:0] r_pend_bytes;
    logic [1:0]        r_pend_cnt;
    logic              r_nz_seen;
    logic [PEND_W-1:0] n_pend_bytes;
    logic [1:0]        n_pend_cnt;
    logic              n_nz_seen;

    // Result buffer.
    t_group     r_grp [4];
    t_group     n_grp [4];
    logic [2:0] r_buf_cnt;
    logic [2:0] n_buf_cnt;
    logic [1:0] r_buf_idx;
    logic       r_buf_fin;

    // Output register.
    logic       r_out_valid;
    t_value     r_value;
    logic       r_final;

    logic [2:0] in_size;
    logic [2:0] grp_size;
    logic       buf_busy;
    logic       out_load;
    logic       take_last;
    logic       in_accept;

    assign in_size  = size_of_code(r_in_width);
    assign grp_size = size_of_code(r_out_width);

    assign buf_busy  = (r_buf_cnt != 3'd0);
    assign out_load  = buf_busy && (!r_out_valid || !i_out_stall);
    assign take_last = out_load && (({1'b0, r_buf_idx} + 3'd1) == r_buf_cnt);
    assign in_accept = i_in_valid && (!buf_busy || take_last);

    assign o_in_stall     = buf_busy && !take_last;
    assign o_out_valid    = r_out_valid;
    assign o_binary_value = r_value;
    assign o_final_result = r_final;

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_width   <= '0;
            r_out_width  <= '0;
            r_skip_zeros <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_INPUT_WIDTH:  r_in_width   <= i_cfg_data[1:0];
                CFG_OUTPUT_WIDTH: r_out_width  <= i_cfg_data[1:0];
                CFG_SKIP_ZEROS:   r_skip_zeros <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Byte sorting: up to four bytes, most significant first, each either
    // closing a group, joining the open one or dropped as a skipped leading zero.
    always_comb begin
        logic [PEND_W-1:0] pend;
        logic [1:0]        pc;
        logic              nz;
        logic [2:0]        rc;
        logic [7:0]        b;
        logic [2:0]        pad;
        t_group            acc;
        pend = r_pend_bytes;
        pc   = r_pend_cnt;
        nz   = r_nz_seen;
        rc   = 3'd0;
        b    = 8'h00;
        pad  = 3'd0;
        acc  = '0;
        for (int k = 0; k < 4; k++) begin
            n_grp[k] = '0;
        end
        for (int k = 3; k >= 0; k--) begin
            b = i_bcd_word[k*8 +: 8];
            if (3'(k) < in_size) begin
                if (!(r_in_width == WCODE_ONE && r_skip_zeros && b == 8'h00 && !nz)) begin
                    nz = 1'b1;
                    if (({1'b0, pc} + 3'd1) >= grp_size) begin
                        // Only the newest group-size bytes count.
                        acc = {pend, b};
                        n_grp[rc[1:0]] = low_bytes(acc, grp_size);
                        rc   = rc + 3'd1;
                        pend = '0;
                        pc   = 2'd0;
                    end else begin
                        pend = {pend[15:0], b};
                        pc   = pc + 2'd1;
                    end
                end
            end
        end
        if (i_final_word) begin
            if (pc != 2'd0) begin
                // A short group is padded with zero bytes at its low end.
                if ({1'b0, pc} < grp_size) begin
                    pad = grp_size - {1'b0, pc};
                    acc = {8'h00, pend} << {pad, 3'b000};
                end else begin
                    acc = {8'h00, pend};
                end
                n_grp[rc[1:0]] = low_bytes(acc, grp_size);
                rc = rc + 3'd1;
            end
            pend = '0;
            pc   = 2'd0;
            nz   = 1'b0;
        end
        n_pend_bytes = pend;
        n_pend_cnt   = pc;
        n_nz_seen    = nz;
        n_buf_cnt    = rc;
    end

    // Stream state and result buffer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_bytes <= '0;
            r_pend_cnt   <= '0;
            r_nz_seen    <= 1'b0;
            r_buf_cnt    <= '0;
            r_buf_idx    <= '0;
        end else if (in_accept) begin
            r_pend_bytes <= n_pend_bytes;
            r_pend_cnt   <= n_pend_cnt;
            r_nz_seen    <= n_nz_seen;
            r_buf_cnt    <= n_buf_cnt;
            r_buf_idx    <= '0;
        end else if (out_load) begin
            if (take_last) begin
                r_buf_cnt <= '0;
            end else begin
                r_buf_idx <= r_buf_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_grp     <= n_grp;
            r_buf_fin <= i_final_word;
        end
    end

    // Output register: one group a cycle while not stalled, weighted on the way in.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_value <= bcd_to_bin(r_grp[r_buf_idx]);
            r_final <= r_buf_fin && take_last;
        end
    end

endmodule
`default_nettype wire

/* tb/bcd_repack_to_binary_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcd_repack_to_binary_test: self-checking bench for the packed-BCD repacker
// Words are sent under several handshake timing patterns while a local
// copy of the byte stream predicts every binary group. Each received group
// is checked against the oldest prediction. The bench covers the width
// extremes, zero skipping, mid-run width changes and a long output hold-off.
// ----------------------------------------------------------------------------
module bcd_repack_to_binary_test;
    import bcdr_pkg::*;

    // Width codes that the package leaves unnamed.
    localparam logic [1:0] WCODE_FOUR  = 2'd2;
    localparam logic [1:0] WCODE_SPARE = 2'd3;

    localparam int CYCLE_LIMIT    = 300000;
    localparam int HOLDOFF_CYCLES = 150;
    localparam int SETTLE_CYCLES  = 8;

    typedef struct {
        logic [VALUE_W-1:0] value;
        logic               run_end;
    } t_group_result;

    logic                  i_clk          = 1'b0;
    logic                  i_rst_n        = 1'b0;
    logic                  i_cfg_we       = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx      = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data     = '0;
    logic                  i_in_valid     = 1'b0;
    logic [WORD_W-1:0]     i_bcd_word     = '0;
    logic                  i_final_word   = 1'b0;
    logic                  i_out_stall    = 1'b0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    logic [VALUE_W-1:0]    o_binary_value;
    logic                  o_final_result;

    // Predictor state: configuration and the open group of the byte stream.
    logic [1:0]  word_code;
    logic [1:0]  group_code;
    logic        drop_zeros;
    logic [23:0] open_group_bytes;
    int          open_group_count;
    logic        run_has_byte;

    t_group_result expected_groups [$];
    t_group_result oldest;

    int  idle_pct;
    int  stall_pct;
    int  holdoff_left;
    bit  holdoff_request;
    int  cycle_count;
    int  error_count;
    int  words_sent;
    int  groups_checked;
    int  run_ends_checked;

    bcd_repack_to_binary dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_idx      (i_cfg_idx),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_bcd_word     (i_bcd_word),
        .i_final_word   (i_final_word),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_binary_value (o_binary_value),
        .o_final_result (o_final_result)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(posedge i_clk) begin
        if (holdoff_request) begin
            holdoff_left = HOLDOFF_CYCLES;
            holdoff_request = 1'b0;
        end
        if (holdoff_left > 0) begin
            i_out_stall <= 1'b1;
            holdoff_left = holdoff_left - 1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_groups.size() == 0) begin
                $error("unexpected result word: binary_value %0d, final_result %0b",
                       o_binary_value, o_final_result);
                error_count++;
            end else begin
                oldest = expected_groups.pop_front();
                groups_checked++;
                if (oldest.run_end)
                    run_ends_checked++;
                if (o_binary_value !== oldest.value) begin
                    $error("binary_value mismatch: expected %0d, got %0d",
                           oldest.value, o_binary_value);
                    error_count++;
                end
                if (o_final_result !== oldest.run_end) begin
                    $error("final_result mismatch: expected %0b, got %0b",
                           oldest.run_end, o_final_result);
                    error_count++;
                end
            end
        end
    end

    function automatic int byte_count(input logic [1:0] code);
        case (code)
            WCODE_ONE: return 1;
            WCODE_TWO: return 2;
            default:   return 4;
        endcase
    endfunction

    // Top nibble first: value = value * 10 + nibble over the low nbytes bytes.
    function automatic logic [VALUE_W-1:0] decimal_weight(input logic [31:0] grp,
                                                          input int nbytes);
        logic [31:0] v;
        v = '0;
        for (int n = nbytes * 2; n > 0; n--)
            v = v * 10 + 32'(grp[(n - 1) * 4 +: 4]);
        return v[VALUE_W-1:0];
    endfunction

    task automatic predict_groups(input logic [31:0] word, input logic run_end);
        t_group_result produced [4];
        int            n_out;
        int            wsz;
        int            gsz;
        logic [7:0]    b;
        logic [31:0]   acc;
        n_out = 0;
        wsz = byte_count(word_code);
        gsz = byte_count(group_code);
        for (int i = wsz; i > 0; i--) begin
            b = word[(i - 1) * 8 +: 8];
            if (!(word_code == WCODE_ONE && drop_zeros && b == 8'h00 && !run_has_byte)) begin
                run_has_byte = 1'b1;
                if (open_group_count + 1 >= gsz) begin
                    // Only the newest group-size bytes count; older ones are lost.
                    acc = {open_group_bytes, b};
                    produced[n_out] = '{decimal_weight(acc, gsz), 1'b0};
                    n_out++;
                    open_group_bytes = '0;
                    open_group_count = 0;
                end else begin
                    open_group_bytes = {open_group_bytes[15:0], b};
                    open_group_count++;
                end
            end
        end
        if (run_end) begin
            if (open_group_count > 0) begin
                acc = {8'h00, open_group_bytes};
                if (open_group_count < gsz)
                    acc = acc << ((gsz - open_group_count) * 8);
                produced[n_out] = '{decimal_weight(acc, gsz), 1'b0};
                n_out++;
            end
            if (n_out > 0)
                produced[n_out - 1].run_end = 1'b1;
            open_group_bytes = '0;
            open_group_count = 0;
            run_has_byte = 1'b0;
        end
        for (int k = 0; k < n_out; k++)
            expected_groups.push_back(produced[k]);
    endtask

    // Offers one word, holds it until taken, then predicts its groups.
    task automatic send_word(input logic [31:0] word, input logic run_end);
        while ($urandom_range(99) < idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_bcd_word   <= word;
        i_final_word <= run_end;
        do
            @(posedge i_clk);
        while (o_in_stall);
        words_sent++;
        predict_groups(word, run_end);
    endtask

    task automatic wait_idle();
        i_in_valid <= 1'b0;
        while (expected_groups.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_INPUT_WIDTH:  word_code  = data;
            CFG_OUTPUT_WIDTH: group_code = data;
            CFG_SKIP_ZEROS:   drop_zeros = data[0];
            default: ;
        endcase
    endtask

    task automatic set_widths(input logic [1:0] wcode, input logic [1:0] gcode,
                              input logic skip);
        write_register(CFG_INPUT_WIDTH, wcode);
        write_register(CFG_OUTPUT_WIDTH, gcode);
        write_register(CFG_SKIP_ZEROS, {1'b0, skip});
    endtask

    // Zero bytes and arbitrary bytes a quarter each, valid digit pairs the other half.
    function automatic logic [7:0] random_byte();
        logic [3:0] hi;
        logic [3:0] lo;
        hi = 4'($urandom_range(9));
        lo = 4'($urandom_range(9));
        case ($urandom_range(3))
            0:       return 8'h00;
            1:       return 8'($urandom);
            default: return {hi, lo};
        endcase
    endfunction

    function automatic logic [31:0] random_word();
        return {random_byte(), random_byte(), random_byte(), random_byte()};
    endfunction

    task automatic test_field_extremes();
        set_widths(WCODE_FOUR, WCODE_FOUR, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        send_word(32'h0000_0000, 1'b1);
        send_word(32'h9999_9999, 1'b1);
        send_word(32'h1234_5678, 1'b0);
        send_word(32'h0000_0009, 1'b1);
        set_widths(WCODE_FOUR, WCODE_ONE, 1'b0);
        send_word(32'hFFFF_FFFF, 1'b1);
        set_widths(WCODE_ONE, WCODE_TWO, 1'b0);
        send_word(32'hABCD_EF12, 1'b1);
        set_widths(WCODE_TWO, WCODE_FOUR, 1'b0);
        send_word(32'h0000_4321, 1'b1);
        // The spare width code behaves as four bytes on both registers.
        set_widths(WCODE_SPARE, WCODE_SPARE, 1'b0);
        send_word(32'h8765_4321, 1'b1);
    endtask

    task automatic test_zero_skipping();
        set_widths(WCODE_ONE, WCODE_TWO, 1'b1);
        send_word(32'hFFFF_FF00, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0005, 1'b0);
        send_word(32'h0000_0000, 1'b0);
        send_word(32'h0000_0007, 1'b1);
        // A run of nothing but zeros leaves no group at all.
        send_word(32'h0000_0000, 1'b1);
        set_widths(WCODE_TWO, WCODE_TWO, 1'b1);
        send_word(32'h0000_0000, 1'b1);
    endtask

    task automatic test_width_changes();
        set_widths(WCODE_ONE, WCODE_FOUR, 1'b0);
        send_word(32'h0000_0011, 1'b0);
        send_word(32'h0000_0022, 1'b0);
        send_word(32'h0000_0033, 1'b0);
        // Three bytes are still open when the group size drops below them.
        write_register(CFG_OUTPUT_WIDTH, WCODE_TWO);
        send_word(32'h0000_0044, 1'b1);
        write_register(CFG_OUTPUT_WIDTH, WCODE_FOUR);
        send_word(32'h0000_0055, 1'b0);
        send_word(32'h0000_0066, 1'b0);
        write_register(CFG_OUTPUT_WIDTH, WCODE_ONE);
        send_word(32'h0000_0077, 1'b1);
    endtask

    // Runs of random length ending on a final word, with some broken runs.
    task automatic test_random_runs(input int sender_idle, input int receiver_stall,
                                    input int n_words);
        int  sent;
        int  run_len;
        bit  broken;
        logic run_end;
        sent = 0;
        idle_pct = sender_idle;
        stall_pct = receiver_stall;
        while (sent < n_words) begin
            if ($urandom_range(3) == 0) begin
                if ($urandom_range(1) == 0)
                    write_register(CFG_INPUT_WIDTH, 2'($urandom_range(3)));
                if ($urandom_range(1) == 0)
                    write_register(CFG_OUTPUT_WIDTH, 2'($urandom_range(3)));
                if ($urandom_range(1) == 0)
                    write_register(CFG_SKIP_ZEROS, 2'($urandom_range(1)));
            end
            run_len = $urandom_range(1, 8);
            broken = ($urandom_range(7) == 0);
            for (int k = 0; k < run_len; k++) begin
                if (broken)
                    run_end = ($urandom_range(9) == 0);
                else
                    run_end = (k == run_len - 1);
                send_word(random_word(), run_end);
                sent++;
            end
        end
        wait_idle();
    endtask

    task automatic test_long_holdoff();
        set_widths(WCODE_FOUR, WCODE_ONE, 1'b0);
        idle_pct = 0;
        stall_pct = 0;
        holdoff_request = 1'b1;
        wait (holdoff_left != 0);
        for (int k = 0; k < 12; k++)
            send_word(random_word(), k == 11);
        wait_idle();
    endtask

    initial begin
        word_code = WCODE_ONE;
        group_code = WCODE_ONE;
        drop_zeros = 1'b0;
        open_group_bytes = '0;
        open_group_count = 0;
        run_has_byte = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        holdoff_left = 0;
        holdoff_request = 1'b0;
        error_count = 0;
        words_sent = 0;
        groups_checked = 0;
        run_ends_checked = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_field_extremes();
        test_zero_skipping();
        test_width_changes();
        test_random_runs(0, 0, 80);
        test_random_runs(79, 0, 60);
        test_random_runs(0, 79, 60);
        test_random_runs(11, 11, 70);
        test_long_holdoff();

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        $display("Covered %0d words over all width codes, zero skipping and four timing",
                 words_sent);
        $display("patterns plus a long output hold-off; %0d groups checked, %0d run ends.",
                 groups_checked, run_ends_checked);
        if (error_count == 0 && expected_groups.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

/* bcd_repack_to_binary.f */
src/bcdr_pkg.sv
src/bcd_repack_to_binary.sv
tb/bcd_repack_to_binary_test.sv
